>>> rtl/core/tile_pair_scatter_top_assert.svh
// Assertion macros for the tile pair scatter RTL.
`ifndef TILE_PAIR_SCATTER_TOP_ASSERT_SVH
`define TILE_PAIR_SCATTER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TPS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define TPS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/tps_pkg.sv
package tps_pkg;

   // Request kinds
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_PAGE = 1'b1;

   // Control register indexes
   typedef logic [2:0] csr_index_type;
   localparam csr_index_type CSR_GAUSSIAN_COUNT = 3'd0;
   localparam csr_index_type CSR_PAIR_COUNT     = 3'd1;
   localparam csr_index_type CSR_GRID_WIDTH     = 3'd2;
   localparam csr_index_type CSR_GRID_HEIGHT    = 3'd3;
   localparam csr_index_type CSR_TILE_PIXELS    = 3'd4;

   // Fraction bits of the Q15.8 coordinates
   localparam int FRAC_BITS = 8;

   // Box bound being divided during a load
   localparam logic [1:0] SEL_LX = 2'd0;
   localparam logic [1:0] SEL_LY = 2'd1;
   localparam logic [1:0] SEL_HX = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LD_GO,
      ST_LD_WAIT,
      ST_LD_WR,
      ST_SRCH,
      ST_SRCH_CMP,
      ST_PAIR,
      ST_ADV,
      ST_BASE,
      ST_BASE_D,
      ST_DIV,
      ST_MUL,
      ST_OUT
   } state_type;

endpackage

>>> rtl/core/tps_if.sv
// Request channel: one load entry or one page request per beat
interface tps_req_if;
   logic               valid;
   logic               ready;
   logic               req_type;
   logic [10:0]        entry_index;
   logic [15:0]        entry_offset;
   logic signed [23:0] center_x;
   logic signed [23:0] center_y;
   logic [22:0]        radius_x;
   logic [22:0]        radius_y;
   logic [11:0]        page_index;

   modport source (output valid, req_type, entry_index, entry_offset, center_x,
                   center_y, radius_x, radius_y, page_index, input ready);
   modport sink (input valid, req_type, entry_index, entry_offset, center_x,
                 center_y, radius_x, radius_y, page_index, output ready);
endinterface

// Response channel: one gaussian/tile pair per beat
interface tps_rsp_if;
   logic        valid;
   logic        ready;
   logic [9:0]  gaussian_id;
   logic [15:0] tile_id;
   logic        last_in_page;

   modport source (output valid, gaussian_id, tile_id, last_in_page, input ready);
   modport sink (input valid, gaussian_id, tile_id, last_in_page, output ready);
endinterface

// Control register write channel
interface tps_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/tile_pair_scatter_top.sv
// Tile pair scatter for gaussian splat binning.
// req_ch beats either load one gaussian (offset, center, radius) or ask for
// one page of PAGE_PAIRS pairs. rsp_ch returns the page as PAGE_PAIRS beats
// in pair order, last_in_page set on the final one; loads return nothing.
// csr_ch writes the control registers; the user is to write them only while the
// block is idle, which the block itself does not enforce. It is always ready.
// A load sends the three box bounds in turn through one shared bit-serial
// divider, one bit per cycle, then writes the box. A page runs a binary search
// (about log2 of the gaussian count probes), then takes each real pair through
// ST_PAIR, ST_ADV (not for the last gaussian), ST_BASE, ST_BASE_D, ST_MUL and
// ST_OUT; each owner step adds ST_PAIR and ST_ADV, and a new owner adds ST_DIV,
// since the tile offset uses the same divider. Padding pairs take ST_PAIR and
// ST_OUT. The memories give one read per cycle, which sets the pace.
// Reset restores the register defaults and idles the control; the memories
// are not cleared and must be loaded before a page is requested.
// The last response beat sits in an output register, so the next request is
// taken while it waits. A stalled rsp_ch holds the walk in place.
`include "tile_pair_scatter_top_assert.svh"

module tile_pair_scatter_top
   import tps_pkg::*;
#(
   parameter int MAX_GAUSSIANS = 1024,
   parameter int PAGE_PAIRS    = 16,
   parameter int MAX_GRID_SIDE = 256
) (
   input  logic  clock,
   input  logic  reset,
   tps_req_if.sink   req_ch,
   tps_rsp_if.source rsp_ch,
   tps_csr_if.sink   csr_ch
);

   localparam int IW   = $clog2(MAX_GAUSSIANS + 1);
   localparam int BW   = $clog2(MAX_GAUSSIANS);
   localparam int WW   = $clog2(MAX_GRID_SIDE + 1);
   localparam int XW   = (MAX_GRID_SIDE > 1) ? $clog2(MAX_GRID_SIDE) : 1;
   localparam int KW   = (PAGE_PAIRS > 1) ? $clog2(PAGE_PAIRS) : 1;
   localparam int PW   = 12 + $clog2(PAGE_PAIRS);
   localparam int NW   = (PW > 16) ? PW : 16;
   localparam int DW   = (WW > 7) ? WW : 7;
   localparam int BOXW = 2 * XW + WW;

   // Control registers
   logic [10:0] gcount_ff;
   logic [15:0] pcount_ff;
   logic [8:0]  gwidth_ff, gheight_ff;
   logic [6:0]  tpix_ff;

   // Effective register values
   logic [31:0]   m_wide, gw_wide, gh_wide;
   logic [IW-1:0] m_eff;
   logic [WW-1:0] gw_eff, gh_eff;
   logic [6:0]    tp_eff;

   // Control and datapath
   state_type          state_ff, state_in;
   logic signed [24:0] lxc_ff, lyc_ff, hxc_ff, lxc_in, lyc_in, hxc_in;
   logic [1:0]         sel_ff, sel_in;
   logic [XW-1:0]      lx_ff, ly_ff, hx_ff, lx_in, ly_in, hx_in;
   logic [BW-1:0]      ld_idx_ff, ld_idx_in;
   logic [PW-1:0]      p0_ff, p0_in;
   logic [IW-1:0]      lo_ff, hi_ff, mid_ff, g_ff, lo_in, hi_in, mid_in, g_in;
   logic [KW-1:0]      k_ff, k_in;
   logic               zero_ff, inc_ok_ff, ge_ff, zero_in, inc_ok_in, ge_in;
   logic [XW-1:0]      minx_ff, miny_ff, minx_in, miny_in;
   logic [WW-1:0]      w_ff, dx_ff, w_in, dx_in;
   logic [15:0]        dy_ff, prod_ff, dy_in, prod_in;
   logic               rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [9:0]         rsp_gid_ff, rsp_gid_in;
   logic [15:0]        rsp_tid_ff, rsp_tid_in;

   // Combinational helpers
   logic               req_fire, out_load;
   logic [PW-1:0]      p_c, local_c;
   logic [IW:0]        mid_sum;
   logic signed [24:0] coord_c;
   logic [WW-1:0]      side_m1, box_w_c, dx_inc;
   logic [XW-1:0]      q_clamp;
   logic               ge_c;

   // Memories
   logic [15:0]     offs_mem [0:MAX_GAUSSIANS];
   logic [BOXW-1:0] box_mem  [0:MAX_GAUSSIANS-1];
   logic            offs_we, box_we;
   logic [IW-1:0]   offs_waddr, offs_raddr;
   logic [BW-1:0]   box_raddr;
   logic [15:0]     offs_rdata_ff;
   logic [BOXW-1:0] box_wdata, box_rdata_ff;

   // Divider
   logic          div_start, div_done;
   logic [NW-1:0] div_num, div_quo;
   logic [DW-1:0] div_den, div_rem;

   tps_div #(.NW(NW), .DW(DW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   // Control register writes
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gcount_ff  <= 11'd1;
         pcount_ff  <= 16'd0;
         gwidth_ff  <= 9'd1;
         gheight_ff <= 9'd1;
         tpix_ff    <= 7'd16;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_GAUSSIAN_COUNT: gcount_ff  <= csr_ch.data[10:0];
            CSR_PAIR_COUNT:     pcount_ff  <= csr_ch.data;
            CSR_GRID_WIDTH:     gwidth_ff  <= csr_ch.data[8:0];
            CSR_GRID_HEIGHT:    gheight_ff <= csr_ch.data[8:0];
            CSR_TILE_PIXELS:    tpix_ff    <= csr_ch.data[6:0];
            default: ;
         endcase
      end
   end

   // Clamp registers to their working ranges
   always_comb begin
      m_wide = 32'(gcount_ff);
      if (m_wide == 32'd0) m_wide = 32'd1;
      else if (m_wide > 32'(MAX_GAUSSIANS)) m_wide = 32'(MAX_GAUSSIANS);
      gw_wide = 32'(gwidth_ff);
      if (gw_wide == 32'd0) gw_wide = 32'd1;
      else if (gw_wide > 32'(MAX_GRID_SIDE)) gw_wide = 32'(MAX_GRID_SIDE);
      gh_wide = 32'(gheight_ff);
      if (gh_wide == 32'd0) gh_wide = 32'd1;
      else if (gh_wide > 32'(MAX_GRID_SIDE)) gh_wide = 32'(MAX_GRID_SIDE);
      m_eff  = IW'(m_wide);
      gw_eff = WW'(gw_wide);
      gh_eff = WW'(gh_wide);
      tp_eff = (tpix_ff == 7'd0) ? 7'd1 : tpix_ff;
   end

   // Offset and box memories, registered read
   always_ff @(posedge clock) begin
      if (offs_we) offs_mem[offs_waddr] <= req_ch.entry_offset;
      offs_rdata_ff <= offs_mem[offs_raddr];
   end

   always_ff @(posedge clock) begin
      if (box_we) box_mem[ld_idx_ff] <= box_wdata;
      box_rdata_ff <= box_mem[box_raddr];
   end

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && (state_ff == ST_IDLE);
   assign out_load     = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ch.ready);

   // Shared helpers
   always_comb begin
      p_c     = p0_ff + PW'(k_ff);
      mid_sum = ({1'b0, lo_ff} + {1'b0, hi_ff} + 1'b1) >> 1;
      priority case (sel_ff)
         SEL_LX:  coord_c = lxc_ff;
         SEL_LY:  coord_c = lyc_ff;
         default: coord_c = hxc_ff;
      endcase
      side_m1 = ((sel_ff == SEL_LY) ? gh_eff : gw_eff) - 1'b1;
      q_clamp = (div_quo > NW'(side_m1)) ? XW'(side_m1) : XW'(div_quo);
      ge_c    = 32'(p_c) >= 32'(offs_rdata_ff);
      local_c = ge_c ? (p_c - PW'(offs_rdata_ff)) : '0;
      box_w_c = (box_rdata_ff[WW-1:0] == '0) ? WW'(1) : box_rdata_ff[WW-1:0];
      dx_inc  = dx_ff + 1'b1;
      box_wdata = {lx_ff, ly_ff, WW'(hx_ff) - WW'(lx_ff) + 1'b1};
   end

   // Next state and datapath
   always_comb begin
      state_in     = state_ff;
      lxc_in       = lxc_ff;
      lyc_in       = lyc_ff;
      hxc_in       = hxc_ff;
      sel_in       = sel_ff;
      lx_in        = lx_ff;
      ly_in        = ly_ff;
      hx_in        = hx_ff;
      ld_idx_in    = ld_idx_ff;
      p0_in        = p0_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      g_in         = g_ff;
      k_in         = k_ff;
      zero_in      = zero_ff;
      inc_ok_in    = inc_ok_ff;
      ge_in        = ge_ff;
      minx_in      = minx_ff;
      miny_in      = miny_ff;
      w_in         = w_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_gid_in   = rsp_gid_ff;
      rsp_tid_in   = rsp_tid_ff;
      rsp_last_in  = rsp_last_ff;
      offs_we      = 1'b0;
      offs_waddr   = IW'(req_ch.entry_index);
      offs_raddr   = g_ff;
      box_we       = 1'b0;
      box_raddr    = g_ff[BW-1:0];
      div_start    = 1'b0;
      div_num      = coord_c[24] ? '0 : NW'(coord_c[23:FRAC_BITS]);
      div_den      = DW'(tp_eff);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_ch.req_type == REQ_LOAD) begin
                  offs_we   = 32'(req_ch.entry_index) <= 32'(MAX_GAUSSIANS);
                  ld_idx_in = BW'(req_ch.entry_index);
                  lxc_in    = 25'(req_ch.center_x) - 25'(signed'({1'b0, req_ch.radius_x}));
                  lyc_in    = 25'(req_ch.center_y) - 25'(signed'({1'b0, req_ch.radius_y}));
                  hxc_in    = 25'(req_ch.center_x) + 25'(signed'({1'b0, req_ch.radius_x}));
                  sel_in    = SEL_LX;
                  if (32'(req_ch.entry_index) < 32'(MAX_GAUSSIANS)) state_in = ST_LD_GO;
               end else begin
                  p0_in    = PW'(32'(req_ch.page_index) * PAGE_PAIRS);
                  lo_in    = '0;
                  hi_in    = m_eff - 1'b1;
                  state_in = ST_SRCH;
               end
            end
         end
         ST_LD_GO: begin
            div_start = 1'b1;
            state_in  = ST_LD_WAIT;
         end
         ST_LD_WAIT: begin
            if (div_done) begin
               priority case (sel_ff)
                  SEL_LX:  lx_in = q_clamp;
                  SEL_LY:  ly_in = q_clamp;
                  default: hx_in = q_clamp;
               endcase
               if (sel_ff == SEL_HX) begin
                  state_in = ST_LD_WR;
               end else begin
                  sel_in   = sel_ff + 1'b1;
                  state_in = ST_LD_GO;
               end
            end
         end
         ST_LD_WR: begin
            box_we   = 1'b1;
            state_in = ST_IDLE;
         end
         // Binary search for the owner of the first pair
         ST_SRCH: begin
            if (lo_ff < hi_ff) begin
               offs_raddr = IW'(mid_sum);
               mid_in     = IW'(mid_sum);
               state_in   = ST_SRCH_CMP;
            end else begin
               g_in      = lo_ff;
               k_in      = '0;
               inc_ok_in = 1'b0;
               state_in  = ST_PAIR;
            end
         end
         ST_SRCH_CMP: begin
            if (32'(offs_rdata_ff) <= 32'(p0_ff)) lo_in = mid_ff;
            else hi_in = mid_ff - 1'b1;
            state_in = ST_SRCH;
         end
         // Padding check, then look at the next gaussian's offset
         ST_PAIR: begin
            if (32'(p_c) >= 32'(pcount_ff)) begin
               zero_in  = 1'b1;
               state_in = ST_OUT;
            end else begin
               zero_in = 1'b0;
               if (32'(g_ff) + 32'd1 < 32'(m_eff)) begin
                  offs_raddr = g_ff + 1'b1;
                  state_in   = ST_ADV;
               end else begin
                  state_in = ST_BASE;
               end
            end
         end
         ST_ADV: begin
            if (32'(p_c) >= 32'(offs_rdata_ff)) begin
               g_in      = g_ff + 1'b1;
               inc_ok_in = 1'b0;
               state_in  = ST_PAIR;
            end else begin
               state_in = ST_BASE;
            end
         end
         ST_BASE: begin
            offs_raddr = g_ff;
            box_raddr  = g_ff[BW-1:0];
            state_in   = ST_BASE_D;
         end
         // Step the tile offset, or divide when the owner is new
         ST_BASE_D: begin
            minx_in = box_rdata_ff[BOXW-1 -: XW];
            miny_in = box_rdata_ff[WW +: XW];
            w_in    = box_w_c;
            ge_in   = ge_c;
            if (inc_ok_ff && ge_c) begin
               if (dx_inc == box_w_c) begin
                  dx_in = '0;
                  dy_in = dy_ff + 1'b1;
               end else begin
                  dx_in = dx_inc;
               end
               state_in = ST_MUL;
            end else begin
               div_start = 1'b1;
               div_num   = NW'(local_c);
               div_den   = DW'(box_w_c);
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               dy_in     = 16'(div_quo);
               dx_in     = WW'(div_rem);
               inc_ok_in = ge_ff;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = 16'(32'(16'(miny_ff) + dy_ff) * 32'(gw_eff));
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_gid_in   = zero_ff ? 10'd0 : 10'(g_ff);
               rsp_tid_in   = zero_ff ? 16'd0 : (prod_ff + 16'(minx_ff) + 16'(dx_ff));
               rsp_last_in  = (k_ff == KW'(PAGE_PAIRS - 1));
               if (k_ff == KW'(PAGE_PAIRS - 1)) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_PAIR;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lxc_ff      <= lxc_in;
      lyc_ff      <= lyc_in;
      hxc_ff      <= hxc_in;
      sel_ff      <= sel_in;
      lx_ff       <= lx_in;
      ly_ff       <= ly_in;
      hx_ff       <= hx_in;
      ld_idx_ff   <= ld_idx_in;
      p0_ff       <= p0_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      g_ff        <= g_in;
      k_ff        <= k_in;
      zero_ff     <= zero_in;
      inc_ok_ff   <= inc_ok_in;
      ge_ff       <= ge_in;
      minx_ff     <= minx_in;
      miny_ff     <= miny_in;
      w_ff        <= w_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      prod_ff     <= prod_in;
      rsp_gid_ff  <= rsp_gid_in;
      rsp_tid_ff  <= rsp_tid_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Response beat
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.gaussian_id  = rsp_gid_ff;
   assign rsp_ch.tile_id      = rsp_tid_ff;
   assign rsp_ch.last_in_page = rsp_last_ff;

   // Checks
   `TPS_ASSERT_IMP(a_div_done_waited, clock, reset, div_done,
      (state_ff == ST_LD_WAIT) || (state_ff == ST_DIV), "divider result with no consumer")
   `TPS_ASSERT_IMP(a_no_overwrite, clock, reset, out_load,
      !rsp_valid_ff || rsp_ch.ready, "response beat overwritten")
   `TPS_ASSERT_IMP(a_owner_range, clock, reset, state_ff == ST_PAIR,
      32'(g_ff) < 32'(m_eff), "owner past gaussian count")
   `TPS_ASSERT_NXT(a_page_ends_idle, clock, reset, out_load && rsp_last_in,
      state_ff == ST_IDLE, "page did not end after last beat")
   `TPS_ASSERT_IMP(a_dx_in_box, clock, reset, state_ff == ST_MUL,
      dx_ff < w_ff, "tile column past box width")

endmodule

>>> rtl/core/tps_div.sv
// Restoring divider, one quotient bit per cycle
module tps_div
   import tps_pkg::*;
#(
   parameter int NW = 16,
   parameter int DW = 9
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          done,
   output logic [NW-1:0] quo,
   output logic [DW-1:0] rem
);

   localparam int CW = $clog2(NW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [DW:0]   rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW:0]   trial;
   logic          fits;

   // One shift-subtract step
   always_comb begin
      trial   = {rem_ff[DW-1:0], quo_ff[NW-1]};
      fits    = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(NW);
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = fits ? (trial - {1'b0, den_ff}) : trial;
         quo_in = {quo_ff[NW-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff[DW-1:0];

endmodule
